>>> design/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared constants and types for the ring FIFO with read-pointer rewind.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int ELEM_BITS_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_REWIND = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

endpackage

>>> design/ring_fifo_with_rewind.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_rewind
// Power-of-two ring FIFO: push, pop, peek, limited read rewind and flush.
// ----------------------------------------------------------------------------
// A result appears in the output register in the cycle after its beat is taken.
// One beat per cycle while in_stall is low; the store is read every cycle at the next
// read pointer, with a one-entry bypass for a push into the entry being read.
// Reset clears pointers, wrap flag and output valid; the store is not cleared.
module ring_fifo_with_rewind
  import rfr_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [DATA_W-1:0]   in_push_data,
  input  logic [COUNT_W-1:0]  in_rewind_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   out_read_data,
  output logic                out_done_res,
  output logic [COUNT_W-1:0]  out_fill_count,
  output logic [COUNT_W-1:0]  out_rewound
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CMP_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [ELEM_BITS-1:0] mem_q_r;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             wrapped_r, wrapped_nxt;

  logic                 fwd_hit_r;
  logic [ELEM_BITS-1:0] fwd_data_r;

  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_read_data_r, out_read_data_nxt;
  logic                 out_done_res_r, out_done_res_nxt;
  logic [COUNT_W-1:0]   out_fill_count_r;
  logic [COUNT_W-1:0]   out_rewound_r, out_rewound_nxt;

  logic                 in_fire;
  logic [PTR_W-1:0]     fill;
  logic [PTR_W-1:0]     fill_nxt;
  logic [PTR_W-1:0]     wr_ptr_inc;
  logic [PTR_W-1:0]     limit;
  logic [CMP_W-1:0]     applied;
  logic                 we;
  logic [ELEM_BITS-1:0] wdata;
  logic [ELEM_BITS-1:0] head_data;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign fill       = wr_ptr_r - rd_ptr_r;
  assign wr_ptr_inc = wr_ptr_r + PTR_W'(1);
  assign limit      = wrapped_r ? (DEPTH_P - fill) : rd_ptr_r;
  assign wdata      = ELEM_BITS'(in_push_data);
  assign head_data  = fwd_hit_r ? fwd_data_r : mem_q_r;

  always_comb begin
    wr_ptr_nxt        = wr_ptr_r;
    rd_ptr_nxt        = rd_ptr_r;
    wrapped_nxt       = wrapped_r;
    we                = 1'b0;
    applied           = '0;
    out_read_data_nxt = '0;
    out_done_res_nxt  = 1'b0;
    if (in_fire) begin
      unique case (in_opcode) inside
        OP_PUSH: begin
          if (fill != DEPTH_P) begin
            we               = 1'b1;
            wr_ptr_nxt       = wr_ptr_inc;
            out_done_res_nxt = 1'b1;
            if (wr_ptr_inc == DEPTH_P) begin
              wrapped_nxt = 1'b1;
            end
          end
        end
        OP_POP, OP_PEEK: begin
          if (fill != '0) begin
            out_read_data_nxt = DATA_W'(head_data);
            out_done_res_nxt  = 1'b1;
            if (in_opcode == OP_POP) begin
              rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
            end
          end
        end
        OP_REWIND: begin
          if (CMP_W'(in_rewind_count) < CMP_W'(limit)) begin
            applied = CMP_W'(in_rewind_count);
          end else begin
            applied = CMP_W'(limit);
          end
          rd_ptr_nxt = rd_ptr_r - PTR_W'(applied);
        end
        OP_FLUSH: begin
          wr_ptr_nxt  = '0;
          rd_ptr_nxt  = '0;
          wrapped_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
    out_rewound_nxt = COUNT_W'(applied);
  end

  assign fill_nxt = wr_ptr_nxt - rd_ptr_nxt;

  // store: read every cycle at the next read pointer, read-before-write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr_r[IDX_W-1:0]] <= wdata;
    end
    mem_q_r    <= mem[rd_ptr_nxt[IDX_W-1:0]];
    fwd_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      wrapped_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wrapped_r <= wrapped_nxt;
      fwd_hit_r <= we && (wr_ptr_r[IDX_W-1:0] == rd_ptr_nxt[IDX_W-1:0]);
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_data_r  <= out_read_data_nxt;
      out_done_res_r   <= out_done_res_nxt;
      out_fill_count_r <= COUNT_W'(fill_nxt);
      out_rewound_r    <= out_rewound_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_done_res   = out_done_res_r;
  assign out_fill_count = out_fill_count_r;
  assign out_rewound    = out_rewound_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= DEPTH_P)
    else $error("fill level above depth");

  a_unwrapped_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !wrapped_r |-> (wr_ptr_r < DEPTH_P))
    else $error("write pointer passed depth without wrap flag");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_PUSH && fill == DEPTH_P)
    |=> (!out_done_res && $stable(wr_ptr_r)))
    else $error("push into full FIFO was taken");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_FLUSH)
    |=> (wr_ptr_r == '0 && rd_ptr_r == '0 && !wrapped_r))
    else $error("flush left pointers set");

  a_rewind_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_REWIND)
    |=> (out_rewound <= $past(in_rewind_count)))
    else $error("rewind applied more than requested");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ring_fifo_with_rewind. A mirror of the ring
// (store, free-running pointers, wrap flag) predicts every result beat from
// the accepted input beats and checks the output beats in order. Stimulus:
// directed corner beats, random mixed traffic under four idle/stall mixes,
// then a fill to full behind a long receiver hold-off that carries the write
// index across the ring boundary, and steady pop/push traffic near full.
// ----------------------------------------------------------------------------
module testbench;
  import rfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIFO_DEPTH   = DEPTH_DEF;
  localparam int IDX_W        = $clog2(DEPTH_DEF);
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [OPCODE_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               done_res;
    logic [COUNT_W-1:0] fill_count;
    logic [COUNT_W-1:0] rewound;
  } fifo_result_t;

  class ring_mirror;
    logic [DATA_W-1:0]  store [FIFO_DEPTH];
    logic [COUNT_W-1:0] wr_ptr;
    logic [COUNT_W-1:0] rd_ptr;
    logic               wrapped;
    fifo_result_t       pending [$];
    int                 errors;

    function new();
      wr_ptr  = '0;
      rd_ptr  = '0;
      wrapped = 1'b0;
      errors  = 0;
    endfunction

    function void apply_op(logic [OPCODE_W-1:0] opc, logic [DATA_W-1:0] data,
                           logic [COUNT_W-1:0] cnt);
      fifo_result_t       r;
      logic [COUNT_W-1:0] level;
      logic [COUNT_W-1:0] limit;
      logic [COUNT_W-1:0] applied;
      r = '0;
      level = wr_ptr - rd_ptr;
      case (opc) inside
        OP_PUSH: begin
          if (level < FIFO_DEPTH) begin
            store[wr_ptr[IDX_W-1:0]] = data;
            wr_ptr = wr_ptr + 1'b1;
            if (!wrapped && wr_ptr == FIFO_DEPTH) wrapped = 1'b1;
            r.done_res = 1'b1;
          end
        end
        OP_POP, OP_PEEK: begin
          if (level != 0) begin
            r.read_data = store[rd_ptr[IDX_W-1:0]];
            if (opc == OP_POP) rd_ptr = rd_ptr + 1'b1;
            r.done_res = 1'b1;
          end
        end
        OP_REWIND: begin
          limit = wrapped ? (COUNT_W'(FIFO_DEPTH) - level) : rd_ptr;
          applied = (cnt < limit) ? cnt : limit;
          rd_ptr = rd_ptr - applied;
          r.rewound = applied;
        end
        OP_FLUSH: begin
          wr_ptr  = '0;
          rd_ptr  = '0;
          wrapped = 1'b0;
        end
        default: ;
      endcase
      r.fill_count = wr_ptr - rd_ptr;
      pending.push_back(r);
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: read_data %h fill_count %0d",
               got.read_data, got.fill_count);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h actual %h", want.read_data, got.read_data);
          errors++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %h actual %h", want.done_res, got.done_res);
          errors++;
        end
        if (got.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d actual %0d", want.fill_count, got.fill_count);
          errors++;
        end
        if (got.rewound !== want.rewound) begin
          $error("rewound: expected %0d actual %0d", want.rewound, got.rewound);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode       = '0;
  logic [DATA_W-1:0]   in_push_data    = '0;
  logic [COUNT_W-1:0]  in_rewind_count = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_done_res;
  logic [COUNT_W-1:0]  out_fill_count;
  logic [COUNT_W-1:0]  out_rewound;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int cycle_count  = 0;

  ring_mirror mirror = new();

  ring_fifo_with_rewind dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_push_data    (in_push_data),
    .in_rewind_count (in_rewind_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_done_res    (out_done_res),
    .out_fill_count  (out_fill_count),
    .out_rewound     (out_rewound)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ring_fifo_with_rewind regression: fail");
    $finish;
  end

  // input beat is mirrored before the output beat is checked
  always @(posedge clk) begin : monitor
    fifo_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        mirror.apply_op(in_opcode, in_push_data, in_rewind_count);
      if (out_valid && !out_stall) begin
        got.read_data  = out_read_data;
        got.done_res   = out_done_res;
        got.fill_count = out_fill_count;
        got.rewound    = out_rewound;
        mirror.check_result(got);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    case ($urandom_range(7)) inside
      0:       return '0;
      1:       return COUNT_W'(FIFO_DEPTH);
      2, 3:    return COUNT_W'($urandom_range(FIFO_DEPTH));
      default: return COUNT_W'($urandom_range(8));
    endcase
  endfunction

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] data,
                           logic [COUNT_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_push_data    <= data;
    in_rewind_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_rand(logic [OPCODE_W-1:0] op);
    send_item(op, rand_word(), rand_count());
  endtask

  task automatic run_random(int n_items);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        burst = $urandom_range(32, 1);
        repeat (burst) send_rand(OP_PUSH);
        sent += burst;
      end else if (pick < 14) begin
        burst = $urandom_range(32, 1);
        repeat (burst) send_rand(OP_POP);
        sent += burst;
      end else begin
        if (pick < 50)      send_rand(OP_PUSH);
        else if (pick < 70) send_rand(OP_POP);
        else if (pick < 79) send_rand(OP_PEEK);
        else if (pick < 91) send_rand(OP_REWIND);
        else if (pick < 93) send_rand(OP_FLUSH);
        else if (pick < 97) send_rand(OPCODE_W'($urandom_range(OP_RSVD_C, OP_RSVD_A)));
        else                send_rand(OP_PEEK);
        sent++;
      end
    end
  endtask

  // near-full traffic: each step pops one and pushes one
  task automatic run_steady(int n_steps);
    int pick;
    repeat (n_steps) begin
      pick = $urandom_range(99);
      if (pick < 6)       send_rand(OP_REWIND);
      else if (pick < 10) send_rand(OP_PEEK);
      send_rand(OP_POP);
      send_rand(OP_PUSH);
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty reads, rewind out of reset, data extremes, rewind limit, spare codes, flush
    send_item(OP_POP, '1, '0);
    send_item(OP_PEEK, '1, '0);
    send_item(OP_REWIND, '0, COUNT_W'(FIFO_DEPTH));
    send_item(OP_PUSH, '0, '0);
    send_item(OP_PUSH, '1, '1);
    send_rand(OP_PUSH);
    send_rand(OP_PEEK);
    send_rand(OP_POP);
    send_rand(OP_POP);
    send_item(OP_REWIND, rand_word(), COUNT_W'(1));
    send_item(OP_REWIND, rand_word(), COUNT_W'(FIFO_DEPTH));
    send_rand(OP_POP);
    send_rand(OP_POP);
    send_rand(OP_POP);
    send_rand(OP_POP);
    send_rand(OP_RSVD_A);
    send_rand(OP_RSVD_B);
    send_rand(OP_RSVD_C);
    send_rand(OP_FLUSH);
    send_item(OP_REWIND, rand_word(), COUNT_W'(5));
    send_rand(OP_PEEK);
    send_rand(OP_PUSH);
    send_rand(OP_POP);
    send_item(OP_REWIND, rand_word(), '0);

    idle_pct = 0;  stall_pct = 0;  run_random(40);
    idle_pct = 81; stall_pct = 0;  run_random(40);
    idle_pct = 0;  stall_pct = 81; run_random(40);
    idle_pct = 34; stall_pct = 34; run_random(45);

    // fill to full with the receiver held off, then overflow and wrap
    send_rand(OP_FLUSH);
    idle_pct = 0; stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (FIFO_DEPTH + 6) send_rand(OP_PUSH);
    send_item(OP_REWIND, rand_word(), COUNT_W'(FIFO_DEPTH));
    repeat (20) send_rand(OP_POP);
    send_item(OP_REWIND, rand_word(), COUNT_W'(FIFO_DEPTH));
    idle_pct = 34; stall_pct = 34;
    run_steady(40);
    run_random(30);

    in_valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending.size() == 0)
      $display("ring_fifo_with_rewind regression: pass");
    else
      $display("ring_fifo_with_rewind regression: fail");
    $finish;
  end

endmodule
